// ===== sv/rac_pkg.sv =====
// ----------------------------------------------------------------------------
// rac_pkg
// Shared types, constants and the gain root table for the RMS compressor.
// ----------------------------------------------------------------------------
package rac_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int MS_W            = 48;
  localparam int DIV_NUM_W       = 64;
  localparam int DIV_DEN_W       = 15;
  localparam int DIV_BITS_STEP   = 4;
  localparam int DIV_STEPS       = DIV_NUM_W / DIV_BITS_STEP;

  localparam logic [17:0] DB_PER_OCT_Q16 = 18'd197283;
  localparam logic [13:0] OCT_PER_DB_Q16 = 14'd10885;

  localparam logic signed [15:0] THRESHOLD_RST = -16'sd3072;
  localparam logic [14:0]        RATIO_RST     = 15'd1024;
  localparam logic [12:0]        WINDOW_RST    = 13'd480;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_RATIO     = 2'd1;
  localparam logic [1:0] REG_WINDOW    = 2'd2;

  typedef struct packed {
    logic signed [15:0] threshold_db;
    logic [14:0]        ratio;
    logic [12:0]        window_frames;
  } cfg_t;

  typedef logic [15:0][30:0] root_tab_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    v    = v_in;
    res  = '0;
    bitv = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // entry k: factor 2^(-2^(k-16)) in Q1.30
  function automatic root_tab_t gen_roots();
    root_tab_t   tab;
    logic [63:0] r;
    r = 64'd1 << 29;
    for (int k = 15; k >= 0; k--) begin
      r      = isqrt64(r << 30);
      tab[k] = r[30:0];
    end
    return tab;
  endfunction

  localparam root_tab_t ROOTS = gen_roots();

endpackage

// ===== sv/rms_audio_compressor.sv =====
// The back sequencer and its shared divider handle one word at a time; words
// take a shorter path when the mean square is zero or no gain is applied.
// Reset: registers return to defaults, mean square cleared, queue emptied.
// ----------------------------------------------------------------------------
// rms_audio_compressor
// Feed-forward RMS compressor with configuration write port.
// ----------------------------------------------------------------------------
module rms_audio_compressor #(
  parameter int SAMPLE_BITS = rac_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [15:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          gain_reduced,
  output logic [15:0]                   reduction_db
);
  import rac_pkg::*;

  localparam int QW = SAMPLE_BITS + MS_W;

  cfg_t                 cfg;
  logic                 q_full;
  logic                 q_push;
  logic [QW-1:0]        q_din;
  logic                 q_pop;
  logic                 q_valid;
  logic [QW-1:0]        q_dout;
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quo;
  logic [SAMPLE_BITS-1:0] y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold_db  <= THRESHOLD_RST;
      cfg.ratio         <= RATIO_RST;
      cfg.window_frames <= WINDOW_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_THRESHOLD: cfg.threshold_db  <= cfg_data;
        REG_RATIO:     cfg.ratio         <= cfg_data[14:0];
        REG_WINDOW:    cfg.window_frames <= cfg_data[12:0];
        default: begin
        end
      endcase
    end
  end

  rac_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample_in (sample_in),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_din)
  );

  rac_fifo #(.WIDTH(QW)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_dout)
  );

  rac_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  rac_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_data       (q_dout),
    .q_pop        (q_pop),
    .div_start    (div_start),
    .div_num      (div_num),
    .div_den      (div_den),
    .div_done     (div_done),
    .div_quo      (div_quo),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample_out   (y),
    .gain_reduced (gain_reduced),
    .reduction_db (reduction_db)
  );

  assign sample_out = y;

endmodule

// ===== sv/rac_front.sv =====
// ----------------------------------------------------------------------------
// rac_front
// Input side: takes a sample word, squares it and scales to Q2.46.
// ----------------------------------------------------------------------------
module rac_front #(
  parameter int SAMPLE_BITS = rac_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [SAMPLE_BITS+rac_pkg::MS_W-1:0] q_data
);
  import rac_pkg::*;

  localparam int SQ_W = 2 * SAMPLE_BITS;
  localparam int SH   = SQ_W - MS_W;
  localparam int SHR  = (SH > 0) ? SH : 0;
  localparam int SHL  = (SH < 0) ? -SH : 0;

  logic [SAMPLE_BITS-1:0] mag;
  logic [SQ_W-1:0]        sq_full;
  logic [SQ_W+MS_W-1:0]   wide;

  always_comb begin
    mag     = sample_in[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample_in) : sample_in;
    sq_full = SQ_W'(mag) * SQ_W'(mag);
    wide    = ({{MS_W{1'b0}}, sq_full} << SHL) >> SHR;
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign q_data   = {sample_in, wide[MS_W-1:0]};

endmodule

// ===== sv/rac_fifo.sv =====
// ----------------------------------------------------------------------------
// rac_fifo
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
module rac_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] dout
);
  import rac_pkg::*;

  logic [WIDTH-1:0] mem [2];
  logic             wp;
  logic             rp;
  logic [1:0]       count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        mem[wp] <= din;
        wp      <= !wp;
      end
      if (pop) begin
        rp <= !rp;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign full  = count[1];
  assign valid = (count != 2'd0);
  assign dout  = mem[rp];

endmodule

// ===== sv/rac_div.sv =====
// ----------------------------------------------------------------------------
// rac_div
// Shared restoring divider, four quotient bits per cycle.
// ----------------------------------------------------------------------------
module rac_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rac_pkg::DIV_NUM_W-1:0] num,
  input  logic [rac_pkg::DIV_DEN_W-1:0] den,
  output logic                          done,
  output logic [rac_pkg::DIV_NUM_W-1:0] quo
);
  import rac_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DIV_NUM_W-1:0] q;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] d;
  logic [DIV_NUM_W-1:0] q_next;
  logic [DIV_DEN_W-1:0] rem_next;

  always_comb begin
    logic [DIV_DEN_W:0] r2;
    q_next   = q;
    rem_next = rem;
    for (int i = 0; i < DIV_BITS_STEP; i++) begin
      r2     = {rem_next, q_next[DIV_NUM_W-1]};
      q_next = {q_next[DIV_NUM_W-2:0], 1'b0};
      if (r2 >= {1'b0, d}) begin
        r2        = r2 - {1'b0, d};
        q_next[0] = 1'b1;
      end
      rem_next = r2[DIV_DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q    <= num;
        rem  <= '0;
        d    <= den;
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        q   <= q_next;
        rem <= rem_next;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = q;

endmodule

// ===== sv/rac_back.sv =====
// ----------------------------------------------------------------------------
// rac_back
// Sequencer: mean-square update, level in dB, reduction, gain, output word.
// ----------------------------------------------------------------------------
module rac_back #(
  parameter int SAMPLE_BITS = rac_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  rac_pkg::cfg_t                        cfg,
  input  logic                                 q_valid,
  input  logic [SAMPLE_BITS+rac_pkg::MS_W-1:0] q_data,
  output logic                                 q_pop,
  output logic                                 div_start,
  output logic [rac_pkg::DIV_NUM_W-1:0]        div_num,
  output logic [rac_pkg::DIV_DEN_W-1:0]        div_den,
  input  logic                                 div_done,
  input  logic [rac_pkg::DIV_NUM_W-1:0]        div_quo,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [SAMPLE_BITS-1:0]               sample_out,
  output logic                                 gain_reduced,
  output logic [15:0]                          reduction_db
);
  import rac_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MSMUL, S_MSDIV, S_NORM, S_LOG, S_DBM, S_CMP, S_RMUL,
    S_RDIV, S_EXPM, S_GAIN, S_SHIFT, S_OMUL, S_FIN
  } state_t;

  state_t                 state;
  logic [SAMPLE_BITS-1:0] raw;
  logic [MS_W-1:0]        sq;
  logic [MS_W-1:0]        ms;
  logic [MS_W-1:0]        v;
  logic [5:0]             z;
  logic [2:0]             step;
  logic [30:0]            m;
  logic [15:0]            frac;
  logic [3:0]             cnt;
  logic [15:0]            lvl_mag;
  logic [16:0]            diff;
  logic [15:0]            red;
  logic [15:0]            f;
  logic [6:0]             ip;
  logic [30:0]            g;
  logic [SAMPLE_BITS-1:0] res_y;
  logic                   res_flag;

  logic [12:0]              n_eff;
  logic [60:0]              ms_prod;
  logic [14:0]              rt;
  logic [31:0]              rprod;
  logic [5:0]               sh_amt;
  logic [30:0]              mm;
  logic [61:0]              msq;
  logic signed [23:0]       a_s;
  logic [22:0]              a_pos;
  logic [40:0]              db_prod;
  logic signed [16:0]       lvl_s;
  logic signed [16:0]       thr_s;
  logic [30:0]              e_sum;
  logic [61:0]              gprod;
  logic [SAMPLE_BITS-1:0]   mag;
  logic [SAMPLE_BITS+30:0]  oprod;
  logic [SAMPLE_BITS:0]     om_full;
  logic [SAMPLE_BITS-1:0]   om;

  always_comb begin
    n_eff   = (cfg.window_frames == 13'd0) ? 13'd1 : cfg.window_frames;
    ms_prod = ms * (n_eff - 13'd1);
    rt      = (cfg.ratio < 15'd256) ? 15'd256 : cfg.ratio;
    rprod   = diff * (rt - 15'd256);
    sh_amt  = 6'd32 >> step;
    mm      = (cnt == 4'd15) ? v[47:17] : m;
    msq     = mm * mm;
    a_s     = 24'(({18'd0, z} - 24'd1) << 16) - 24'(frac);
    a_pos   = a_s[23] ? 23'd0 : a_s[22:0];
    db_prod = a_pos * DB_PER_OCT_Q16;
    lvl_s   = -$signed({1'b0, lvl_mag});
    thr_s   = 17'(cfg.threshold_db);
    e_sum   = red * OCT_PER_DB_Q16 + 31'd128;
    gprod   = g * ROOTS[cnt];
    mag     = raw[SAMPLE_BITS-1] ? SAMPLE_BITS'(-$signed(raw)) : raw;
    oprod   = mag * g;
    om_full = (SAMPLE_BITS+1)'((oprod + (SAMPLE_BITS+31)'(1 << 29)) >> 30);
    om      = om_full[SAMPLE_BITS-1:0];
  end

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign div_start = (state == S_MSMUL) || (state == S_RMUL);
  assign div_num   = (state == S_MSMUL) ? 64'(ms_prod) + 64'(sq) : 64'(rprod);
  assign div_den   = (state == S_MSMUL) ? 15'(n_eff) : rt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ms        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            raw   <= q_data[SAMPLE_BITS+MS_W-1:MS_W];
            sq    <= q_data[MS_W-1:0];
            state <= S_MSMUL;
          end
        end
        S_MSMUL: begin
          state <= S_MSDIV;
        end
        S_MSDIV: begin
          if (div_done) begin
            ms       <= div_quo[MS_W-1:0];
            v        <= div_quo[MS_W-1:0];
            z        <= 6'd0;
            step     <= 3'd0;
            res_y    <= raw;
            res_flag <= 1'b0;
            red      <= 16'd0;
            state    <= (div_quo[MS_W-1:0] == '0) ? S_FIN : S_NORM;
          end
        end
        S_NORM: begin
          if ((v >> (7'd48 - {1'b0, sh_amt})) == '0) begin
            v <= v << sh_amt;
            z <= z + sh_amt;
          end
          step <= step + 3'd1;
          if (step == 3'd5) begin
            cnt   <= 4'd15;
            frac  <= 16'd0;
            state <= S_LOG;
          end
        end
        S_LOG: begin
          if (msq[61]) begin
            m    <= msq[61:31];
            frac <= {frac[14:0], 1'b1};
          end else begin
            m    <= msq[60:30];
            frac <= {frac[14:0], 1'b0};
          end
          cnt <= cnt - 4'd1;
          if (cnt == 4'd0) begin
            state <= S_DBM;
          end
        end
        S_DBM: begin
          lvl_mag <= 16'((db_prod + 41'd8388608) >> 24);
          state   <= S_CMP;
        end
        S_CMP: begin
          if (lvl_s > thr_s) begin
            diff  <= 17'(lvl_s - thr_s);
            state <= S_RMUL;
          end else begin
            state <= S_FIN;
          end
        end
        S_RMUL: begin
          state <= S_RDIV;
        end
        S_RDIV: begin
          if (div_done) begin
            red   <= (div_quo[63:16] != '0) ? 16'hFFFF : div_quo[15:0];
            state <= S_EXPM;
          end
        end
        S_EXPM: begin
          f     <= e_sum[23:8];
          ip    <= e_sum[30:24];
          g     <= 31'd1 << 30;
          cnt   <= 4'd15;
          state <= S_GAIN;
        end
        S_GAIN: begin
          if (f[cnt]) begin
            g <= gprod[60:30];
          end
          cnt <= cnt - 4'd1;
          if (cnt == 4'd0) begin
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          g     <= (ip >= 7'd40) ? 31'd0 : (g >> ip);
          state <= S_OMUL;
        end
        S_OMUL: begin
          res_y    <= raw[SAMPLE_BITS-1] ? SAMPLE_BITS'(-om) : om;
          res_flag <= 1'b1;
          state    <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            sample_out   <= res_y;
            gain_reduced <= res_flag;
            reduction_db <= red;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_MSDIV || state == S_RDIV))
    else $error("divider finished outside a wait state");

  a_no_red_when_pass: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !gain_reduced) |-> (reduction_db == 16'd0))
    else $error("reduction reported without gain reduction");

  a_pop_starts: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == S_MSMUL))
    else $error("queue pop did not start an update");
`endif

endmodule
